### rtl/idbc_pkg.sv
// shared types, defaults and codes of the interval double booking check
// no dependencies: compiled first

package idbc_pkg;

    // defaults for the top level parameters
    localparam int MAX_BOOKINGS_DEF = 64;
    localparam int MAX_DOUBLES_DEF  = 64;
    localparam int TIME_BITS_DEF    = 32;

    // fixed widths of the item fields
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;
    localparam int HELD_W   = 7;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_ACCEPTED = 2'd0,
        STS_TRIPLE   = 2'd1,
        STS_FULL     = 2'd2,
        STS_EMPTY    = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DSCAN = 4'b0010,
        S_BSCAN = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

endpackage

### rtl/idbc_ifs.sv
// request and result channel interfaces of the interval double booking check
// depends on idbc_pkg

interface idbc_req_if;
    logic                       valid;
    logic                       ready;
    logic [idbc_pkg::TIME_W-1:0] start_time;
    logic [idbc_pkg::TIME_W-1:0] end_time;

    modport source (output valid, output start_time, output end_time, input ready);
    modport sink   (input valid, input start_time, input end_time, output ready);
endinterface

interface idbc_res_if;
    logic                         valid;
    logic                         ready;
    logic [idbc_pkg::STATUS_W-1:0] status;
    logic [idbc_pkg::HELD_W-1:0]   bookings_held;

    modport source (output valid, output status, output bookings_held, input ready);
    modport sink   (input valid, input status, input bookings_held, output ready);
endinterface

### rtl/idbc_span_cmp.sv
// shared span compare unit: overlap test and intersection of two half-open spans
// no package dependencies

module idbc_span_cmp #(
    parameter int TIME_BITS = 32
) (
    input  logic [TIME_BITS-1:0] i_a_lo,
    input  logic [TIME_BITS-1:0] i_a_hi,
    input  logic [TIME_BITS-1:0] i_b_lo,
    input  logic [TIME_BITS-1:0] i_b_hi,
    output logic                 o_meet,
    output logic [TIME_BITS-1:0] o_lo,
    output logic [TIME_BITS-1:0] o_hi
);

    // spans meet when each starts before the other ends
    assign o_meet = (i_a_lo < i_b_hi) && (i_b_lo < i_a_hi);

    // intersection: later start, earlier end
    assign o_lo = (i_a_lo > i_b_lo) ? i_a_lo : i_b_lo;
    assign o_hi = (i_a_hi < i_b_hi) ? i_a_hi : i_b_hi;

endmodule

### rtl/interval_double_booking_check_unit.sv
// interval double booking check: top level with sequencer and both span tables
// depends on idbc_pkg, idbc_ifs and idbc_span_cmp
//
// usage
//   i_req carries one requested half-open interval [start_time, end_time) per
//   item; o_res returns one item per request with a status (accepted, triple
//   booking, table full, empty interval) and the booking count afterwards.
//   the block works on one request at a time and drops ready while busy.
//   a request first reads the double table, then the booking table, one entry
//   a cycle through a single shared span compare unit; the memories have a
//   registered read. a full booking table skips the booking scan, and an
//   empty interval skips both scans. ready returns together with result
//   valid, so a new request is taken only once the last one has its
//   result and has left the sequencer.
//   the result sits in an output register: a new request is taken while it
//   waits, and a finished request holds in its final state until the slot is
//   free, so a stalled receiver only delays the next result.
//   reset (synchronous, active low) empties both tables by clearing the
//   counts; no clearing pass is needed and the block is ready at once.

module interval_double_booking_check_unit #(
    parameter int MAX_BOOKINGS = idbc_pkg::MAX_BOOKINGS_DEF,
    parameter int MAX_DOUBLES  = idbc_pkg::MAX_DOUBLES_DEF,
    parameter int TIME_BITS    = idbc_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    idbc_req_if.sink    i_req,
    idbc_res_if.source  o_res
);

    localparam int CW_B = $clog2(MAX_BOOKINGS + 1);
    localparam int CW_D = $clog2(MAX_DOUBLES + 1);
    localparam int AW_B = (MAX_BOOKINGS > 1) ? $clog2(MAX_BOOKINGS) : 1;
    localparam int AW_D = (MAX_DOUBLES > 1) ? $clog2(MAX_DOUBLES) : 1;
    localparam int IW   = (CW_B > CW_D) ? CW_B : CW_D;
    localparam int DPW  = $clog2(MAX_DOUBLES + MAX_BOOKINGS + 1);
    localparam int SW   = 2 * TIME_BITS;

    // control state
    idbc_pkg::t_state  r_state, n_state;
    logic [CW_B-1:0]   r_bcount, n_bcount;
    logic [CW_D-1:0]   r_dcount, n_dcount;
    logic [IW-1:0]     r_idx, n_idx;
    logic [DPW-1:0]    r_dptr, n_dptr;
    logic              r_rd_vld, n_rd_vld;
    logic              r_out_vld, n_out_vld;

    // payload
    logic [TIME_BITS-1:0]               r_s, n_s;
    logic [TIME_BITS-1:0]               r_e, n_e;
    idbc_pkg::t_status                  r_pend, n_pend;
    idbc_pkg::t_status                  r_status, n_status;
    logic [idbc_pkg::HELD_W-1:0]        r_held, n_held;

    // tables and their read registers
    logic [SW-1:0] r_bmem [MAX_BOOKINGS];
    logic [SW-1:0] r_dmem [MAX_DOUBLES];
    logic [SW-1:0] r_b_rd;
    logic [SW-1:0] r_d_rd;

    logic                 d_issue, b_issue;
    logic                 bmem_we, dmem_we;
    logic                 req_fire;
    logic [TIME_BITS-1:0] req_s, req_e;
    logic [TIME_BITS-1:0] ent_lo, ent_hi;
    logic                 cmp_meet;
    logic [TIME_BITS-1:0] cmp_lo, cmp_hi;

    assign req_fire = i_req.valid && i_req.ready;
    assign req_s    = i_req.start_time[TIME_BITS-1:0];
    assign req_e    = i_req.end_time[TIME_BITS-1:0];

    // one table read a cycle while entries remain
    assign d_issue = (r_state == idbc_pkg::S_DSCAN) && (r_idx < IW'(r_dcount));
    assign b_issue = (r_state == idbc_pkg::S_BSCAN) && (r_idx < IW'(r_bcount));

    // entry under test comes from the table being scanned
    assign ent_lo = (r_state == idbc_pkg::S_BSCAN) ? r_b_rd[SW-1:TIME_BITS]
                                                   : r_d_rd[SW-1:TIME_BITS];
    assign ent_hi = (r_state == idbc_pkg::S_BSCAN) ? r_b_rd[TIME_BITS-1:0]
                                                   : r_d_rd[TIME_BITS-1:0];

    idbc_span_cmp #(
        .TIME_BITS (TIME_BITS)
    ) u_cmp (
        .i_a_lo (r_s),
        .i_a_hi (r_e),
        .i_b_lo (ent_lo),
        .i_b_hi (ent_hi),
        .o_meet (cmp_meet),
        .o_lo   (cmp_lo),
        .o_hi   (cmp_hi)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_bcount  = r_bcount;
        n_dcount  = r_dcount;
        n_idx     = (d_issue || b_issue) ? r_idx + IW'(1) : r_idx;
        n_rd_vld  = d_issue || b_issue;
        n_dptr    = r_dptr;
        n_out_vld = r_out_vld;
        n_s       = r_s;
        n_e       = r_e;
        n_pend    = r_pend;
        n_status  = r_status;
        n_held    = r_held;
        bmem_we   = 1'b0;
        dmem_we   = 1'b0;

        // result taken by the receiver
        if (r_out_vld && o_res.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            idbc_pkg::S_IDLE: begin
                if (req_fire) begin
                    n_s      = req_s;
                    n_e      = req_e;
                    n_idx    = '0;
                    n_rd_vld = 1'b0;
                    if (req_e <= req_s) begin
                        n_pend  = idbc_pkg::STS_EMPTY;
                        n_state = idbc_pkg::S_FIN;
                    end else begin
                        n_state = idbc_pkg::S_DSCAN;
                    end
                end
            end
            idbc_pkg::S_DSCAN: begin
                // any doubly booked overlap means a triple booking
                if (r_rd_vld && cmp_meet) begin
                    n_pend  = idbc_pkg::STS_TRIPLE;
                    n_state = idbc_pkg::S_FIN;
                end else if (!r_rd_vld && !d_issue) begin
                    if (r_bcount >= CW_B'(MAX_BOOKINGS)) begin
                        n_pend  = idbc_pkg::STS_FULL;
                        n_state = idbc_pkg::S_FIN;
                    end else begin
                        n_idx   = '0;
                        n_dptr  = DPW'(r_dcount);
                        n_state = idbc_pkg::S_BSCAN;
                    end
                end
            end
            idbc_pkg::S_BSCAN: begin
                // overlaps go in past the committed count, kept only on success
                if (r_rd_vld && cmp_meet) begin
                    n_dptr = r_dptr + DPW'(1);
                    if (r_dptr < DPW'(MAX_DOUBLES)) begin
                        dmem_we = 1'b1;
                    end
                end else if (!r_rd_vld && !b_issue) begin
                    n_state = idbc_pkg::S_FIN;
                    if (r_dptr > DPW'(MAX_DOUBLES)) begin
                        n_pend = idbc_pkg::STS_FULL;
                    end else begin
                        n_pend   = idbc_pkg::STS_ACCEPTED;
                        n_dcount = CW_D'(r_dptr);
                        n_bcount = r_bcount + CW_B'(1);
                        bmem_we  = 1'b1;
                    end
                end
            end
            idbc_pkg::S_FIN: begin
                // wait for a free output slot
                if (!r_out_vld || o_res.ready) begin
                    n_out_vld = 1'b1;
                    n_status  = r_pend;
                    n_held    = idbc_pkg::HELD_W'(r_bcount);
                    n_state   = idbc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = idbc_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= idbc_pkg::S_IDLE;
            r_bcount  <= '0;
            r_dcount  <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bcount  <= n_bcount;
            r_dcount  <= n_dcount;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_dptr   <= n_dptr;
        r_s      <= n_s;
        r_e      <= n_e;
        r_pend   <= n_pend;
        r_status <= n_status;
        r_held   <= n_held;
    end

    // booking table
    always_ff @(posedge i_clk) begin
        if (bmem_we) begin
            r_bmem[r_bcount[AW_B-1:0]] <= {r_s, r_e};
        end
        if (b_issue) begin
            r_b_rd <= r_bmem[r_idx[AW_B-1:0]];
        end
    end

    // double table
    always_ff @(posedge i_clk) begin
        if (dmem_we) begin
            r_dmem[r_dptr[AW_D-1:0]] <= {cmp_lo, cmp_hi};
        end
        if (d_issue) begin
            r_d_rd <= r_dmem[r_idx[AW_D-1:0]];
        end
    end

    assign i_req.ready         = (r_state == idbc_pkg::S_IDLE);
    assign o_res.valid         = r_out_vld;
    assign o_res.status        = r_status;
    assign o_res.bookings_held = r_held;

endmodule

### rtl/idbc_checker.sv
// port level checks of the interval double booking check, bound to the top level
// depends on idbc_pkg and interval_double_booking_check_unit

module idbc_checker #(
    parameter int MAX_BOOKINGS = idbc_pkg::MAX_BOOKINGS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [idbc_pkg::STATUS_W-1:0] i_status,
    input logic [idbc_pkg::HELD_W-1:0]   i_held
);

    // a stalled result item holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_status) && $stable(i_held))
        else $error("result item changed while stalled");

    // no result item right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // one request at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while busy");

    // booking count never passes the table depth
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (MAX_BOOKINGS > 127) || (int'(i_held) <= MAX_BOOKINGS))
        else $error("bookings held above table depth");

endmodule

bind interval_double_booking_check_unit idbc_checker #(
    .MAX_BOOKINGS (MAX_BOOKINGS)
) u_idbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_held      (o_res.bookings_held)
);

### test/tb_interval_double_booking_check_unit.sv
// self-checking testbench for the interval double booking check unit
// depends on idbc_pkg, idbc_ifs and the top level interval_double_booking_check_unit

module tb_interval_double_booking_check_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import idbc_pkg::*;

    localparam int N_BOOKINGS   = MAX_BOOKINGS_DEF;
    localparam int N_DOUBLES    = MAX_DOUBLES_DEF;
    localparam int N_TIME_BITS  = TIME_BITS_DEF;
    localparam int N_RANDOM     = 1230;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = N_BOOKINGS + N_DOUBLES + 20;

    typedef logic [TIME_W-1:0] t_time;

    // expected outcome of one request
    typedef struct packed {
        t_status             status;
        logic [HELD_W-1:0]   held;
    } t_verdict;

    // mirror of both span tables, turns accepted requests into expected verdicts
    class booking_scoreboard;
        t_time    booking_lo [N_BOOKINGS];
        t_time    booking_hi [N_BOOKINGS];
        int       n_bookings;
        t_time    double_lo [N_DOUBLES];
        t_time    double_hi [N_DOUBLES];
        int       n_doubles;
        t_verdict verdict_q [$];
        int       mismatches;

        function new();
            n_bookings = 0;
            n_doubles  = 0;
            mismatches = 0;
        endfunction

        // half-open spans meet when each starts before the other ends
        function bit spans_meet(t_time a_lo, t_time a_hi, t_time b_lo, t_time b_hi);
            return (a_lo < b_hi) && (b_lo < a_hi);
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        function void note_request(t_time start_in, t_time end_in);
            logic [63:0] tmask;
            t_time       s;
            t_time       e;
            t_status     st;
            int          hits;
            t_verdict    v;
            tmask = (64'd1 << N_TIME_BITS) - 64'd1;
            s     = start_in & tmask[TIME_W-1:0];
            e     = end_in & tmask[TIME_W-1:0];
            st    = STS_ACCEPTED;
            hits  = 0;
            if (e <= s) begin
                st = STS_EMPTY;
            end else begin
                // any overlap with a double region would make a triple booking
                for (int i = 0; i < n_doubles; i++) begin
                    if (st == STS_ACCEPTED && spans_meet(s, e, double_lo[i], double_hi[i]))
                        st = STS_TRIPLE;
                end
                if (st == STS_ACCEPTED) begin
                    for (int i = 0; i < n_bookings; i++) begin
                        if (spans_meet(s, e, booking_lo[i], booking_hi[i]))
                            hits++;
                    end
                    if (n_bookings >= N_BOOKINGS || n_doubles + hits > N_DOUBLES)
                        st = STS_FULL;
                end
                // commit: every overlap becomes a double region, then store the span
                if (st == STS_ACCEPTED) begin
                    for (int i = 0; i < n_bookings; i++) begin
                        if (spans_meet(s, e, booking_lo[i], booking_hi[i])) begin
                            double_lo[n_doubles] = (s > booking_lo[i]) ? s : booking_lo[i];
                            double_hi[n_doubles] = (e < booking_hi[i]) ? e : booking_hi[i];
                            n_doubles++;
                        end
                    end
                    booking_lo[n_bookings] = s;
                    booking_hi[n_bookings] = e;
                    n_bookings++;
                end
            end
            v.status = st;
            v.held   = n_bookings[HELD_W-1:0];
            verdict_q.push_back(v);
        endfunction

        function void check_result(t_status status, logic [HELD_W-1:0] held);
            t_verdict v;
            if (verdict_q.size() == 0) begin
                $error("result with nothing expected: status %0d bookings_held %0d",
                       status, held);
                mismatches++;
                return;
            end
            v = verdict_q.pop_front();
            if (status !== v.status) begin
                $error("status: expected %s actual %0d", v.status.name(), status);
                mismatches++;
            end
            if (held !== v.held) begin
                $error("bookings_held: expected %0d actual %0d", v.held, held);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   steady = 1'b0;
    int   fresh_slot = 0;

    booking_scoreboard sb = new();

    idbc_req_if req_ch ();
    idbc_res_if res_ch ();

    interval_double_booking_check_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    always #2 i_clk = ~i_clk;

    // hand one request to the block and note it once accepted
    task automatic issue_request(input t_time s, input t_time e);
        while (!steady && $urandom_range(99) < 14) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.start_time <= s;
        req_ch.end_time   <= e;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(s, e);
    endtask

    // random request: mostly short spans in a crowded window, some in free space
    task automatic random_request(output t_time s, output t_time e);
        int pick;
        pick = $urandom_range(99);
        if (pick < 6) begin
            s = 32'h1000_0000 + fresh_slot * 64 + $urandom_range(15);
            e = s + $urandom_range(1, 40);
            fresh_slot++;
        end else if (pick < 66) begin
            s = $urandom_range(3999);
            e = s + $urandom_range(1, 300);
        end else if (pick < 76) begin
            s = $urandom_range(3999);
            e = s + 1;
        end else if (pick < 86) begin
            // end not above start
            s = $urandom;
            e = ($urandom_range(2) == 0) ? s : (s & $urandom);
        end else begin
            s = $urandom;
            e = $urandom;
        end
    endtask

    // request side and end of run
    initial begin
        t_time s;
        t_time e;
        req_ch.valid      <= 1'b0;
        req_ch.start_time <= '0;
        req_ch.end_time   <= '0;
        i_rst_n           <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // touching spans, overlaps, triple bookings, empty spans, time extremes
        issue_request(32'd10, 32'd20);
        issue_request(32'd20, 32'd30);
        issue_request(32'd15, 32'd25);
        issue_request(32'd18, 32'd19);
        issue_request(32'd25, 32'd26);
        issue_request(32'd5, 32'd5);
        issue_request(32'd7, 32'd3);
        issue_request(32'h0000_0000, 32'hFFFF_FFFF);
        issue_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        issue_request(32'h0000_0000, 32'h0000_0001);
        issue_request(32'hFFFF_FFFF, 32'h0000_0000);
        issue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_request(32'h8000_0000, 32'hFFFF_FFFF);
        issue_request(32'h7FFF_FFFF, 32'h8000_0001);
        issue_request(32'h8000_0000, 32'h8000_0001);
        issue_request(32'h5555_5555, 32'hAAAA_AAAA);
        issue_request(32'h2AAA_AAAA, 32'h5555_5555);
        issue_request(32'd29, 32'd40);

        // random part, with a stretch where neither side idles
        for (int k = 0; k < N_RANDOM; k++) begin
            steady = (k >= 500 && k < 700);
            random_request(s, e);
            issue_request(s, e);
        end
        steady = 1'b0;
        req_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // result side: check accepted results, stall at random
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready)
                sb.check_result(t_status'(res_ch.status), res_ch.bookings_held);
            res_ch.ready <= steady || ($urandom_range(99) >= 14);
        end
    end

    // watchdog on cycles without any accepted item
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule
